/* rtl/bwds_pkg.sv */
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer package
// Shared widths, types, mode and command codes, and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bwds_pkg;

  // Timing and limit constants
  localparam int unsigned TICK_MS     = 100;
  localparam int unsigned SUBTICKS    = 10;
  localparam int unsigned MAX_BURN_MS = 10000;

  // Register reset values; the burn time reset is held to the burn limit too.
  localparam int unsigned BURN_RESET_RAW = 3000;
  localparam int unsigned BURN_RESET     =
    (BURN_RESET_RAW > MAX_BURN_MS) ? MAX_BURN_MS : BURN_RESET_RAW;
  localparam int unsigned WINDOW_RESET   = 60;

  // Field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned RESP_W  = 2;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SUB_W   = 4;

  // Configuration port widths
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [RESP_W-1:0]  resp_t;
  typedef logic [MS_W-1:0]    ms_t;
  typedef logic [SEC_W-1:0]   sec_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SUB_W-1:0]   sub_t;
  typedef logic [PADDR_W-1:0] paddr_t;
  typedef logic [PDATA_W-1:0] pdata_t;

  // Input command codes
  localparam func_t FUNC_TICK       = 3'd0;
  localparam func_t FUNC_DEPLOY_REQ = 3'd1;
  localparam func_t FUNC_ARM        = 3'd2;
  localparam func_t FUNC_DISARM     = 3'd3;
  localparam func_t FUNC_DEPLOY_CMD = 3'd4;

  // Modes
  localparam mode_t MODE_DISARMED = 2'd0;
  localparam mode_t MODE_ARMED    = 2'd1;
  localparam mode_t MODE_BURNING  = 2'd2;
  localparam mode_t MODE_DEPLOYED = 2'd3;

  // Responses
  localparam resp_t RESP_NONE     = 2'd0;
  localparam resp_t RESP_ACCEPTED = 2'd1;
  localparam resp_t RESP_REJECTED = 2'd2;

  // Register indexes (word address bits of paddr)
  localparam logic [1:0] REG_BURN_TIME  = 2'd0;
  localparam logic [1:0] REG_ARM_WINDOW = 2'd1;
  localparam logic [1:0] REG_SAFETY_KEY = 2'd2;

  localparam ms_t  TICK_STEP    = ms_t'(TICK_MS);
  localparam ms_t  BURN_LIMIT   = ms_t'(MAX_BURN_MS);
  localparam sub_t SUBTICK_LAST = sub_t'(SUBTICKS);

endpackage

`default_nettype wire

/* rtl/bwds_in_if.sv */
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel that carries one command word into the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwds_in_if;
  logic             valid;
  logic             ready;
  bwds_pkg::func_t  func;
  logic             force_req;
  bwds_pkg::key_t   key;

  modport source (output valid, output func, output force_req, output key,
                  input ready);
  modport sink   (input valid, input func, input force_req, input key,
                  output ready);
endinterface

`default_nettype wire

/* rtl/bwds_out_if.sv */
// ----------------------------------------------------------------------------
// Status channel interface
// Valid/ready channel that carries one status word out of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwds_out_if;
  logic              valid;
  logic              ready;
  bwds_pkg::resp_t   response;
  logic              burn_gate;
  bwds_pkg::mode_t   mode;
  logic              armed_flag;
  bwds_pkg::ms_t     burn_left_ms;
  bwds_pkg::sec_t    window_left_sec;
  bwds_pkg::count_t  fire_count;

  modport source (output valid, output response, output burn_gate, output mode,
                  output armed_flag, output burn_left_ms, output window_left_sec,
                  output fire_count, input ready);
  modport sink   (input valid, input response, input burn_gate, input mode,
                  input armed_flag, input burn_left_ms, input window_left_sec,
                  input fire_count, output ready);
endinterface

`default_nettype wire

/* rtl/burn_wire_deploy_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer core
// Key-guarded arm/fire/burn controller with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one command word per clock cycle while out_ch.ready drains
// the status register, and returns one status word per command, in the cycle
// after acceptance, from a single output register; in_ch.ready stays high
// while the status register is empty or being drained in the same cycle. Ticks
// step the burn down by TICK_MS and, while armed, step the arm window down
// once every SUBTICKS ticks. Registers: burn time at 0x0 (writes clamp to
// MAX_BURN_MS), arm window at 0x4 (zero never expires) and safety key at
// 0x8. Write the registers only while no command is in flight.
`default_nettype none

module burn_wire_deploy_sequencer_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bwds_in_if.sink               in_ch,
  bwds_out_if.source            out_ch,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire bwds_pkg::paddr_t paddr,
  input  wire bwds_pkg::pdata_t pwdata,
  output bwds_pkg::pdata_t      prdata,
  output logic                  pready
);
  import bwds_pkg::*;

  // Configuration registers
  ms_t  burn_time_r;
  sec_t arm_window_r;
  key_t safety_key_r;

  // Sequencer state
  mode_t  mode_r,     mode_nxt;
  logic   gate_r,     gate_nxt;
  ms_t    burn_left_r, burn_left_nxt;
  sec_t   window_r,   window_nxt;
  sub_t   subtick_r,  subtick_nxt;
  count_t fires_r,    fires_nxt;
  resp_t  resp_nxt;

  // Status register
  logic   out_valid_r;
  resp_t  out_resp_r;
  logic   out_gate_r;
  mode_t  out_mode_r;
  ms_t    out_burn_r;
  sec_t   out_window_r;
  count_t out_fires_r;

  logic   in_take;
  logic   cfg_wr;
  logic [1:0] cfg_idx;
  ms_t    wr_burn;
  logic   key_ok;
  sub_t   subtick_inc;

  // APB access decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];
  assign wr_burn = (pwdata[MS_W-1:0] > BURN_LIMIT) ? BURN_LIMIT : pwdata[MS_W-1:0];

  always_comb begin
    unique case (cfg_idx)
      REG_BURN_TIME:  prdata = pdata_t'(burn_time_r);
      REG_ARM_WINDOW: prdata = pdata_t'(arm_window_r);
      REG_SAFETY_KEY: prdata = pdata_t'(safety_key_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burn_time_r  <= ms_t'(BURN_RESET);
      arm_window_r <= sec_t'(WINDOW_RESET);
      safety_key_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BURN_TIME:  burn_time_r  <= wr_burn;
        REG_ARM_WINDOW: arm_window_r <= pwdata[SEC_W-1:0];
        REG_SAFETY_KEY: safety_key_r <= pwdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel handshake: accept while the status register is free or draining
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_take     = in_ch.valid & in_ch.ready;

  assign key_ok      = (in_ch.key == safety_key_r);
  assign subtick_inc = subtick_r + sub_t'(1);

  // Command decode and next state
  always_comb begin
    mode_nxt      = mode_r;
    gate_nxt      = gate_r;
    burn_left_nxt = burn_left_r;
    window_nxt    = window_r;
    subtick_nxt   = subtick_r;
    fires_nxt     = fires_r;
    resp_nxt      = RESP_NONE;
    unique case (in_ch.func)
      FUNC_TICK: begin
        // Burn countdown, ending in deployed
        if (mode_r == MODE_BURNING) begin
          if (burn_left_r <= TICK_STEP) begin
            gate_nxt      = 1'b0;
            burn_left_nxt = '0;
            mode_nxt      = MODE_DEPLOYED;
          end else begin
            burn_left_nxt = burn_left_r - TICK_STEP;
          end
        end
        // Arm window countdown, one second per SUBTICKS ticks
        if (mode_r == MODE_ARMED && window_r != '0) begin
          if (subtick_inc >= SUBTICK_LAST) begin
            subtick_nxt = '0;
            window_nxt  = window_r - sec_t'(1);
            if (window_r == sec_t'(1)) begin
              mode_nxt = MODE_DISARMED;
            end
          end else begin
            subtick_nxt = subtick_inc;
          end
        end
      end
      FUNC_DEPLOY_REQ: begin
        if (mode_r == MODE_ARMED || in_ch.force_req) begin
          mode_nxt      = MODE_BURNING;
          gate_nxt      = 1'b1;
          burn_left_nxt = burn_time_r;
          fires_nxt     = (fires_r == '1) ? fires_r : fires_r + count_t'(1);
        end
      end
      FUNC_ARM: begin
        if (key_ok) begin
          mode_nxt   = MODE_ARMED;
          window_nxt = arm_window_r;
          resp_nxt   = RESP_ACCEPTED;
        end else begin
          resp_nxt   = RESP_REJECTED;
        end
      end
      FUNC_DISARM: begin
        if (mode_r == MODE_BURNING) begin
          gate_nxt      = 1'b0;
          burn_left_nxt = '0;
        end
        mode_nxt   = MODE_DISARMED;
        window_nxt = '0;
        resp_nxt   = RESP_ACCEPTED;
      end
      FUNC_DEPLOY_CMD: begin
        if (key_ok) begin
          mode_nxt      = MODE_BURNING;
          gate_nxt      = 1'b1;
          burn_left_nxt = burn_time_r;
          fires_nxt     = (fires_r == '1) ? fires_r : fires_r + count_t'(1);
          resp_nxt      = RESP_ACCEPTED;
        end else begin
          resp_nxt      = RESP_REJECTED;
        end
      end
      default: ;
    endcase
  end

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DISARMED;
      gate_r      <= 1'b0;
      burn_left_r <= '0;
      window_r    <= '0;
      subtick_r   <= '0;
      fires_r     <= '0;
    end else if (in_take) begin
      mode_r      <= mode_nxt;
      gate_r      <= gate_nxt;
      burn_left_r <= burn_left_nxt;
      window_r    <= window_nxt;
      subtick_r   <= subtick_nxt;
      fires_r     <= fires_nxt;
    end
  end

  // Status register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Status register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_resp_r   <= resp_nxt;
      out_gate_r   <= gate_nxt;
      out_mode_r   <= mode_nxt;
      out_burn_r   <= burn_left_nxt;
      out_window_r <= window_nxt;
      out_fires_r  <= fires_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.response        = out_resp_r;
  assign out_ch.burn_gate       = out_gate_r;
  assign out_ch.mode            = out_mode_r;
  assign out_ch.armed_flag      = (out_mode_r == MODE_ARMED);
  assign out_ch.burn_left_ms    = out_burn_r;
  assign out_ch.window_left_sec = out_window_r;
  assign out_ch.fire_count      = out_fires_r;

  // A burn always has the gate on.
  a_burn_gate_on: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_BURNING |-> gate_r)
    else $error("burning without gate drive");

  // Once deployed, the burn is fully over.
  a_deployed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DEPLOYED |-> (!gate_r && burn_left_r == '0))
    else $error("deployed with burn still active");

  // A disarmed block holds no arm window.
  a_disarmed_window: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DISARMED |-> window_r == '0)
    else $error("window left while disarmed");

  // The subtick divider never reaches its wrap value.
  a_subtick_range: assert property (@(posedge clk) disable iff (!rst_n)
    subtick_r < SUBTICK_LAST)
    else $error("subtick counter out of range");

  // The fire counter never goes down.
  a_fires_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fires_r >= $past(fires_r))
    else $error("fire counter decreased");

endmodule

`default_nettype wire

/* tb/tb_burn_wire_deploy_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer core testbench
// Sends command words through the input channel, tracks the expected status
// of every word with a cycle-free model of the sequencer, and compares each
// status word the block returns, while both channel sides idle and stall.
// ----------------------------------------------------------------------------

module tb_burn_wire_deploy_sequencer_core;
  import bwds_pkg::*;

  localparam func_t FUNC_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    resp_t  response;
    logic   burn_gate;
    mode_t  mode;
    logic   armed_flag;
    ms_t    burn_left_ms;
    sec_t   window_left_sec;
    count_t fire_count;
  } status_t;

  logic   clk;
  logic   rst_n;
  logic   psel;
  logic   penable;
  logic   pwrite;
  paddr_t paddr;
  pdata_t pwdata;
  pdata_t prdata;
  logic   pready;

  bwds_in_if  cmd_if ();
  bwds_out_if sts_if ();

  burn_wire_deploy_sequencer_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_if),
    .out_ch  (sts_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Sequencer state as the block should hold it, plus its register copies.
  mode_t   seq_mode;
  logic    seq_gate;
  ms_t     seq_burn_left;
  sec_t    seq_window;
  sub_t    seq_subtick;
  count_t  seq_fires;
  ms_t     cfg_burn_time;
  sec_t    cfg_window;
  key_t    cfg_key;

  status_t expected_status[$];
  int      fail_count;
  int      sender_idle_pct;
  int      receiver_stall_pct;
  int      hold_off_left;

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gate on, full burn time loaded, one more burn counted.
  function automatic void start_burn();
    seq_mode      = MODE_BURNING;
    seq_burn_left = cfg_burn_time;
    if (seq_fires != '1) begin
      seq_fires = seq_fires + 1'b1;
    end
    seq_gate = 1'b1;
  endfunction

  function automatic void finish_burn();
    seq_gate      = 1'b0;
    seq_burn_left = '0;
    seq_mode      = MODE_DEPLOYED;
  endfunction

  // Apply one command word to the tracked state and return the status word.
  function automatic status_t predict_status(func_t f, logic frc, key_t k);
    status_t s;
    resp_t   r;
    r = RESP_NONE;
    case (f)
      FUNC_TICK: begin
        if (seq_mode == MODE_BURNING) begin
          if (seq_burn_left <= TICK_STEP) finish_burn();
          else seq_burn_left = seq_burn_left - TICK_STEP;
        end
        // The arm window only runs down while armed with a nonzero window.
        if (seq_mode == MODE_ARMED && seq_window != '0) begin
          seq_subtick = seq_subtick + 1'b1;
          if (seq_subtick >= SUBTICK_LAST) begin
            seq_subtick = '0;
            seq_window  = seq_window - 1'b1;
            if (seq_window == '0) seq_mode = MODE_DISARMED;
          end
        end
      end
      FUNC_DEPLOY_REQ: begin
        if (seq_mode == MODE_ARMED || frc) start_burn();
      end
      FUNC_ARM: begin
        if (k != cfg_key) begin
          r = RESP_REJECTED;
        end else begin
          seq_mode   = MODE_ARMED;
          seq_window = cfg_window;
          r          = RESP_ACCEPTED;
        end
      end
      FUNC_DISARM: begin
        if (seq_mode == MODE_BURNING) finish_burn();
        seq_mode   = MODE_DISARMED;
        seq_window = '0;
        r          = RESP_ACCEPTED;
      end
      FUNC_DEPLOY_CMD: begin
        if (k != cfg_key) begin
          r = RESP_REJECTED;
        end else begin
          start_burn();
          r = RESP_ACCEPTED;
        end
      end
      default: begin
      end
    endcase
    s.response        = r;
    s.burn_gate       = seq_gate;
    s.mode            = seq_mode;
    s.armed_flag      = (seq_mode == MODE_ARMED);
    s.burn_left_ms    = seq_burn_left;
    s.window_left_sec = seq_window;
    s.fire_count      = seq_fires;
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Status checker: a word seen valid and ready at the falling edge is taken
  // at the next rising edge, and its fields are stable until then.
  always @(negedge clk) begin
    status_t want;
    if (rst_n && sts_if.valid && sts_if.ready) begin
      if (expected_status.size() == 0) begin
        fail_count++;
        $display("%0t: status word with none expected, expected none, actual mode %0d",
                 $time, sts_if.mode);
      end else begin
        want = expected_status.pop_front();
        check_field("response", want.response, sts_if.response);
        check_field("burn_gate", want.burn_gate, sts_if.burn_gate);
        check_field("mode", want.mode, sts_if.mode);
        check_field("armed_flag", want.armed_flag, sts_if.armed_flag);
        check_field("burn_left_ms", want.burn_left_ms, sts_if.burn_left_ms);
        check_field("window_left_sec", want.window_left_sec, sts_if.window_left_sec);
        check_field("fire_count", want.fire_count, sts_if.fire_count);
      end
    end
  end

  // Status receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    sts_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        sts_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        sts_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one command word and wait until it is taken; returns at that edge.
  task automatic send_word(func_t f, logic frc, key_t k);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.func      <= f;
    cmd_if.force_req <= frc;
    cmd_if.key       <= k;
    @(negedge clk);
    while (!cmd_if.ready) @(negedge clk);
    @(posedge clk);
    expected_status.push_back(predict_status(f, frc, k));
  endtask

  // Stop offering words and wait until every status word has come back.
  task automatic wait_drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // Register write while the block is idle: setup cycle, then access cycle.
  task automatic cfg_write(logic [1:0] idx, pdata_t value);
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BURN_TIME:  cfg_burn_time = (value[15:0] > BURN_LIMIT) ? BURN_LIMIT : value[15:0];
      REG_ARM_WINDOW: cfg_window    = value[15:0];
      REG_SAFETY_KEY: cfg_key       = value;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Mostly the right key, otherwise one flipped bit or a random key.
  function automatic key_t pick_key(int good_pct);
    if ($urandom_range(99) < good_pct) return cfg_key;
    if ($urandom_range(1)) return cfg_key ^ (32'h1 << $urandom_range(31));
    return $urandom();
  endfunction

  task automatic send_random_word();
    int    pick;
    func_t f;
    logic  frc;
    key_t  k;
    pick = $urandom_range(99);
    frc  = ($urandom_range(3) == 0);
    k    = $urandom();
    if (pick < 8) begin
      f   = func_t'($urandom_range(7));
      frc = 1'($urandom_range(1));
    end else if (pick < 50) begin
      f = FUNC_TICK;
    end else if (pick < 65) begin
      f = FUNC_ARM;
      k = pick_key(80);
    end else if (pick < 78) begin
      f = FUNC_DEPLOY_REQ;
    end else if (pick < 88) begin
      f = FUNC_DEPLOY_CMD;
      k = pick_key(70);
    end else begin
      f = FUNC_DISARM;
    end
    send_word(f, frc, k);
  endtask

  // Every command under the reset register values.
  task automatic test_directed_commands();
    send_word(FUNC_TICK, 1'b0, '0);
    send_word(FUNC_ARM, 1'b0, '1);
    send_word(FUNC_DEPLOY_REQ, 1'b0, '0);
    send_word(FUNC_DEPLOY_REQ, 1'b1, '0);
    send_word(FUNC_TICK, 1'b0, '0);
    send_word(FUNC_DEPLOY_CMD, 1'b0, 32'h8000_0000);
    // A keyed deploy while burning restarts the burn and counts again.
    send_word(FUNC_DEPLOY_CMD, 1'b0, '0);
    send_word(FUNC_DISARM, 1'b0, '1);
    send_word(FUNC_ARM, 1'b0, '0);
    repeat (3) send_word(FUNC_TICK, 1'b1, '1);
    // Re-arming reloads the window but keeps the subtick count.
    send_word(FUNC_ARM, 1'b0, '0);
    send_word(FUNC_DEPLOY_REQ, 1'b0, '1);
    send_word(FUNC_DISARM, 1'b0, '0);
    for (int u = 0; u < 3; u++) send_word(func_t'(FUNC_UNUSED_FIRST + u), 1'b1, '1);
    send_word(FUNC_DEPLOY_CMD, 1'b1, '0);
  endtask

  // Register extremes: zero burn, zero window, clamped burn, tick boundaries.
  task automatic test_config_extremes();
    cfg_write(REG_SAFETY_KEY, '1);
    cfg_write(REG_BURN_TIME, '0);
    cfg_write(REG_ARM_WINDOW, '0);
    send_word(FUNC_ARM, 1'b0, '1);
    repeat (12) send_word(FUNC_TICK, 1'b0, '0);
    send_word(FUNC_DEPLOY_REQ, 1'b0, '0);
    send_word(FUNC_TICK, 1'b0, '0);
    send_word(FUNC_DEPLOY_CMD, 1'b0, '0);

    cfg_write(REG_BURN_TIME, 32'hFFFF_FFFF);
    cfg_write(REG_ARM_WINDOW, 32'd1);
    cfg_write(REG_SAFETY_KEY, 32'h5A5A_A5A5);
    send_word(FUNC_ARM, 1'b0, 32'h5A5A_A5A5);
    repeat (10) send_word(FUNC_TICK, 1'b0, '0);
    send_word(FUNC_DEPLOY_CMD, 1'b0, 32'h5A5A_A5A5);
    send_word(FUNC_DISARM, 1'b0, '0);

    cfg_write(REG_BURN_TIME, 32'd100);
    send_word(FUNC_DEPLOY_CMD, 1'b0, 32'h5A5A_A5A5);
    send_word(FUNC_TICK, 1'b0, '0);
    cfg_write(REG_BURN_TIME, 32'd101);
    send_word(FUNC_DEPLOY_CMD, 1'b0, 32'h5A5A_A5A5);
    repeat (2) send_word(FUNC_TICK, 1'b0, '0);

    cfg_write(REG_BURN_TIME, 32'd10000);
    cfg_write(REG_ARM_WINDOW, 32'd65535);
    send_word(FUNC_ARM, 1'b0, 32'h5A5A_A5A5);
    send_word(FUNC_TICK, 1'b0, '0);
    send_word(FUNC_DEPLOY_REQ, 1'b0, '0);
  endtask

  // Random traffic in phases, each with its own registers and idling mix.
  task automatic test_random_traffic();
    int idle_mix[5]  = '{0, 79, 0, 21, 0};
    int stall_mix[5] = '{0, 0, 79, 21, 0};
    int pick;
    for (int p = 0; p < 5; p++) begin
      pick = $urandom_range(3);
      cfg_write(REG_BURN_TIME, (pick == 0) ? 32'd0 :
                               (pick == 3) ? pdata_t'($urandom()) : $urandom_range(1, 700));
      cfg_write(REG_ARM_WINDOW, ($urandom_range(4) == 0) ? 32'd0 : $urandom_range(1, 3));
      cfg_write(REG_SAFETY_KEY, $urandom());
      sender_idle_pct    = idle_mix[p];
      receiver_stall_pct = stall_mix[p];
      repeat (100) send_random_word();
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  // Long receiver hold-off while words keep coming, so the input stalls.
  task automatic test_output_backpressure();
    wait_drain();
    hold_off_left = 60;
    repeat (30) send_random_word();
    wait_drain();
  endtask

  // Forced deploy requests and keyed deploys in a row keep counting burns.
  task automatic test_repeated_fires();
    repeat (20) send_word(FUNC_DEPLOY_REQ, 1'b1, $urandom());
    repeat (3) send_word(FUNC_DEPLOY_CMD, 1'b0, cfg_key);
    send_word(FUNC_DEPLOY_REQ, 1'b1, '0);
  endtask

  // Run timeout.
  initial begin
    #10_000_000;
    $display("FAIL burn_wire_deploy_sequencer_core");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.func      <= FUNC_TICK;
    cmd_if.force_req <= 1'b0;
    cmd_if.key       <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    fail_count         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_left      = 0;
    seq_mode      = MODE_DISARMED;
    seq_gate      = 1'b0;
    seq_burn_left = '0;
    seq_window    = '0;
    seq_subtick   = '0;
    seq_fires     = '0;
    cfg_burn_time = ms_t'(BURN_RESET);
    cfg_window    = sec_t'(WINDOW_RESET);
    cfg_key       = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_commands();
    test_config_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_repeated_fires();

    wait_drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS burn_wire_deploy_sequencer_core");
    end else begin
      $display("FAIL burn_wire_deploy_sequencer_core");
    end
    $finish;
  end

endmodule
